// ===== design/ambi_pkg.sv =====
package ambi_pkg;

  localparam int TABLE_SIZE_D  = 1024;
  localparam int ANGLE_BITS_D  = 16;
  localparam int SAMPLE_BITS_D = 24;
  localparam int CFG_W         = 16;
  localparam int TRIG_W        = 18;
  localparam int GAIN_W        = 20;
  localparam int FIFO_DEPTH    = 4;

  // pi in Q30 radians
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  localparam logic [0:0] REG_AZIMUTH   = 1'b0;
  localparam logic [0:0] REG_ELEVATION = 1'b1;

  localparam logic signed [GAIN_W-1:0] K_W = 20'sd23170;
  localparam logic signed [GAIN_W-1:0] K_L = 20'sd23796;
  localparam logic signed [GAIN_W-1:0] K_N = 20'sd85134;

  localparam logic [3:0] CH_W = 4'd0;
  localparam logic [3:0] CH_X = 4'd1;
  localparam logic [3:0] CH_Y = 4'd2;
  localparam logic [3:0] CH_Z = 4'd3;
  localparam logic [3:0] CH_R = 4'd4;
  localparam logic [3:0] CH_S = 4'd5;
  localparam logic [3:0] CH_T = 4'd6;
  localparam logic [3:0] CH_U = 4'd7;
  localparam logic [3:0] CH_V = 4'd8;
  localparam logic [3:0] CH_K = 4'd9;
  localparam logic [3:0] CH_L = 4'd10;
  localparam logic [3:0] CH_M = 4'd11;
  localparam logic [3:0] CH_N = 4'd12;
  localparam logic [3:0] CH_O = 4'd13;
  localparam logic [3:0] CH_P = 4'd14;
  localparam logic [3:0] CH_Q = 4'd15;

  // rounded Q15 product
  function automatic logic signed [GAIN_W-1:0] qm(input logic signed [GAIN_W-1:0] a,
                                                  input logic signed [GAIN_W-1:0] b);
    logic signed [2*GAIN_W-1:0] p;
    p = a * b + 40'sd16384;
    qm = GAIN_W'(p >>> 15);
  endfunction

  typedef struct packed {
    logic signed [SAMPLE_BITS_D-1:0] sample;
    logic [3:0]                      channel;
  } item_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sa1, ca1, sa2, ca2, sa3, ca3, se1, ce1, se2;
  } trig_set_t;

endpackage

// ===== design/ambi_trig.sv =====
// Evaluates the nine angle functions from one sine table, one per cycle, then holds them.
module ambi_trig #(
  parameter int TABLE_SIZE = ambi_pkg::TABLE_SIZE_D,
  parameter int ANGLE_BITS = ambi_pkg::ANGLE_BITS_D
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [ANGLE_BITS-1:0]    azimuth,
  input  logic [ANGLE_BITS-1:0]    elevation,
  input  logic                     recalc,
  output logic                     ready,
  output ambi_pkg::trig_set_t      trig
);
  import ambi_pkg::*;

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int PW = ANGLE_BITS + IW;
  localparam int AW = ANGLE_BITS + 18;

  wire signed [15:0] rom [0:TABLE_SIZE];

  // table fixed at elaboration: quarter-wave fold, Q30 radians, 8-term Taylor series
  for (genvar gi = 0; gi < TABLE_SIZE; gi++) begin : g_rom
    localparam longint unsigned N   = longint'(TABLE_SIZE);
    localparam longint unsigned V0  = 4 * longint'(gi);
    localparam bit              NEG = V0 >= 2 * N;
    localparam longint unsigned V1  = NEG ? V0 - 2 * N : V0;
    localparam longint unsigned V2  = (V1 > N) ? 2 * N - V1 : V1;
    localparam longint unsigned X   = (V2 * PI_Q30 + N) / (2 * N);
    localparam longint unsigned X2  = (X * X) >> 30;
    localparam longint unsigned T1  = ((X * X2) >> 30) / 6;
    localparam longint unsigned T2  = ((T1 * X2) >> 30) / 20;
    localparam longint unsigned T3  = ((T2 * X2) >> 30) / 42;
    localparam longint unsigned T4  = ((T3 * X2) >> 30) / 72;
    localparam longint unsigned T5  = ((T4 * X2) >> 30) / 110;
    localparam longint unsigned T6  = ((T5 * X2) >> 30) / 156;
    localparam longint unsigned T7  = ((T6 * X2) >> 30) / 210;
    localparam longint S = longint'(X) - longint'(T1) + longint'(T2) - longint'(T3)
                         + longint'(T4) - longint'(T5) + longint'(T6) - longint'(T7);
    localparam longint unsigned R0 =
      ($unsigned(S < 0 ? 64'sd0 : S) * 32768 + (64'd1 << 29)) >> 30;
    localparam longint R = (R0 > 32767) ? 32767 : longint'(R0);
    assign rom[gi] = NEG ? 16'(-R) : 16'(R);
  end
  assign rom[TABLE_SIZE] = 16'sd0;

  logic [3:0] step_r, step_nxt;
  logic       busy_r, busy_nxt;
  logic [3:0] wstep_r;
  logic       wen_r;
  logic signed [15:0] s0_r, s1_r;
  logic [ANGLE_BITS-1:0] f_r;
  trig_set_t trig_r;

  logic [ANGLE_BITS-1:0] ang, ph;
  logic [1:0]            mult;
  logic                  cosine;
  logic [PW-1:0]         pos;
  logic [IW-1:0]         idx;
  logic [IW:0]           idx1;
  logic signed [AW-1:0]  acc;
  logic signed [TRIG_W-1:0] val;

  always_comb begin
    ang = azimuth;
    mult = 2'd1;
    cosine = 1'b0;
    case (step_r)
      4'd0: begin mult = 2'd1; cosine = 1'b0; end
      4'd1: begin mult = 2'd1; cosine = 1'b1; end
      4'd2: begin mult = 2'd2; cosine = 1'b0; end
      4'd3: begin mult = 2'd2; cosine = 1'b1; end
      4'd4: begin mult = 2'd3; cosine = 1'b0; end
      4'd5: begin mult = 2'd3; cosine = 1'b1; end
      4'd6: begin ang = elevation; mult = 2'd1; cosine = 1'b0; end
      4'd7: begin ang = elevation; mult = 2'd1; cosine = 1'b1; end
      default: begin ang = elevation; mult = 2'd2; cosine = 1'b0; end
    endcase
    ph = ANGLE_BITS'(ang * mult) + (cosine ? ANGLE_BITS'(1) << (ANGLE_BITS - 2) : '0);
    pos = PW'(ph) * PW'(TABLE_SIZE);
    idx = IW'(pos >> ANGLE_BITS);
    idx1 = {1'b0, idx} + 1'b1;
    acc = AW'(s0_r) * $signed({1'b0, (AW-1)'((AW'(1) << ANGLE_BITS) - AW'(f_r))})
        + AW'(s1_r) * $signed({1'b0, (AW-1)'(f_r)})
        + (AW'(1) << (ANGLE_BITS - 1));
    val = TRIG_W'(acc >>> ANGLE_BITS);
  end

  assign busy_nxt = recalc ? 1'b1 : (busy_r && step_r == 4'd8) ? 1'b0 : busy_r;
  assign step_nxt = recalc ? 4'd0 : (busy_r && step_r != 4'd8) ? step_r + 4'd1 : step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      step_r <= 4'd0;
      wen_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      wen_r  <= busy_r && !recalc;
    end
    wstep_r <= step_r;
    s0_r    <= rom[idx];
    s1_r    <= rom[idx1];
    f_r     <= ANGLE_BITS'(pos);
    if (wen_r) begin
      case (wstep_r)
        4'd0: trig_r.sa1 <= val;
        4'd1: trig_r.ca1 <= val;
        4'd2: trig_r.sa2 <= val;
        4'd3: trig_r.ca2 <= val;
        4'd4: trig_r.sa3 <= val;
        4'd5: trig_r.ca3 <= val;
        4'd6: trig_r.se1 <= val;
        4'd7: trig_r.ce1 <= val;
        default: trig_r.se2 <= val;
      endcase
    end
  end

  assign ready = !busy_r && !wen_r;
  assign trig  = trig_r;
endmodule

// ===== design/ambi_fifo.sv =====
// Small queue between command front end and encode pipeline.
module ambi_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ambi_pkg::item_t   din,
  input  logic              pop,
  output logic              not_empty,
  output logic              full,
  output ambi_pkg::item_t   dout
);
  import ambi_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);
  item_t mem_r [FIFO_DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r, cnt_nxt;

  assign cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wp_r] <= din;
  end

  assign not_empty = cnt_r != '0;
  assign full      = cnt_r == (AW+1)'(FIFO_DEPTH);
  assign dout      = mem_r[rp_r];
endmodule

// ===== design/ambi_gain.sv =====
// Pipelined gain and sample product: one item per cycle, 6 stages.
module ambi_gain (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_vld,
  input  ambi_pkg::item_t                         item,
  input  ambi_pkg::trig_set_t                     trig,
  output logic                                    out_vld,
  output logic signed [ambi_pkg::SAMPLE_BITS_D-1:0] out_val
);
  import ambi_pkg::*;

  localparam int SAMPLE_BITS = SAMPLE_BITS_D;
  localparam int GW = GAIN_W;
  localparam int PW = SAMPLE_BITS + GW;

  // stage 1: operands of the first product
  logic [5:0] vld_r;
  logic [3:0] ch1_r, ch2_r, ch3_r, ch4_r;
  logic signed [SAMPLE_BITS-1:0] smp_r [5];
  logic signed [GW-1:0] a1_r, b1_r, s2_r, se1_r, ce1_r;
  logic signed [GW-1:0] p2_r, p3_r, g_r;
  logic signed [GW-1:0] a, b, ce, se, m2, p2, p3, p4, g;
  logic signed [PW-1:0] r;
  logic signed [SAMPLE_BITS-1:0] sat;

  always_comb begin
    ce = GW'(trig.ce1);
    se = GW'(trig.se1);
    a = GW'(trig.ca1);
    b = ce;
    case (item.channel)
      CH_X: begin a = GW'(trig.ca1); b = ce; end
      CH_Y: begin a = GW'(trig.sa1); b = ce; end
      CH_S: begin a = GW'(trig.ca1); b = GW'(trig.se2); end
      CH_T: begin a = GW'(trig.sa1); b = GW'(trig.se2); end
      CH_U, CH_N: begin a = GW'(trig.ca2); b = (item.channel == CH_N) ? se : ce; end
      CH_V, CH_O: begin a = GW'(trig.sa2); b = (item.channel == CH_O) ? se : ce; end
      CH_L: begin a = GW'(trig.ca1); b = se; end
      CH_M: begin a = GW'(trig.sa1); b = se; end
      CH_P: begin a = GW'(trig.ca3); b = ce; end
      CH_W: begin a = se; b = se; end
      default: begin
        if (item.channel == CH_Z || item.channel == CH_R || item.channel == CH_K) begin
          a = se; b = se;
        end else begin
          a = GW'(trig.sa3); b = ce;
        end
      end
    endcase
  end

  // stage 2 needs s2 for L and M
  always_comb begin
    m2 = qm(a1_r, b1_r);
    p2 = m2;
    case (ch1_r)
      CH_L, CH_M: p2 = qm(a1_r, GW'(20'sd5 * s2_r - 20'sd32768));
      default: p2 = m2;
    endcase
  end

  always_comb begin
    p3 = p2_r;
    case (ch2_r)
      CH_U, CH_V, CH_N, CH_O, CH_P, CH_Q, CH_L, CH_M: p3 = qm(p2_r, ce1_r);
      CH_K: p3 = qm(se1_r, GW'(20'sd5 * p2_r - 20'sd98304));
      default: p3 = p2_r;
    endcase
  end

  always_comb begin
    p4 = p3_r;
    case (ch3_r)
      CH_W: p4 = K_W;
      CH_Z: p4 = se1_r;
      CH_R: p4 = GW'((20'sd3 * p3_r - 20'sd32768 + 20'sd1) >>> 1);
      CH_K: p4 = GW'((p3_r + 20'sd1) >>> 1);
      CH_L, CH_M: p4 = qm(p3_r, K_L);
      CH_N, CH_O, CH_P, CH_Q: p4 = qm(p3_r, ce1_r);
      default: p4 = p3_r;
    endcase
  end

  always_comb begin
    g = g_r;
    if (ch4_r == CH_N || ch4_r == CH_O) g = qm(g_r, K_N);
  end

  logic signed [GW-1:0] g6_r;
  always_comb begin
    r = (PW'(smp_r[4]) * PW'(g6_r) + PW'(16384)) >>> 15;
    if (r > $signed(PW'({1'b0, {(SAMPLE_BITS-1){1'b1}}})))
      sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    else if (r < -PW'(1) <<< (SAMPLE_BITS - 1)) sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    else sat = SAMPLE_BITS'(r);
  end

  logic signed [SAMPLE_BITS-1:0] res_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[4:0], in_vld};
    smp_r[0] <= SAMPLE_BITS'(item.sample);
    for (int i = 1; i < 5; i++) smp_r[i] <= smp_r[i-1];
    ch1_r <= item.channel;
    a1_r <= a;
    b1_r <= b;
    se1_r <= se;
    ce1_r <= ce;
    s2_r <= qm(se, se);
    ch2_r <= ch1_r;
    p2_r <= (ch1_r == CH_R || ch1_r == CH_K) ? qm(a1_r, b1_r) : p2;
    ch3_r <= ch2_r;
    p3_r <= p3;
    ch4_r <= ch3_r;
    g_r <= p4;
    g6_r <= g;
    res_r <= sat;
  end

  assign out_vld = vld_r[5];
  assign out_val = res_r;
endmodule

// ===== design/ambisonic_third_order_encoder.sv =====
// Third-order ambisonic encoder (FuMa order, MaxN weights).
// Items go via the FIFO and gain pipeline; one item per cycle when busy is low.
// After reset or a register write, the angle unit refills its nine trig values
// (one table lookup per cycle); busy is high meanwhile.
// Synchronous active-low reset; results cannot be stalled by the receiver.
module ambisonic_third_order_encoder #(
  parameter int TABLE_SIZE  = ambi_pkg::TABLE_SIZE_D,
  parameter int ANGLE_BITS  = ambi_pkg::ANGLE_BITS_D
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      start,
  output logic                                      busy,
  input  logic signed [ambi_pkg::SAMPLE_BITS_D-1:0] in_sample,
  input  logic [3:0]                                in_channel,
  output logic                                      out_valid,
  output logic signed [ambi_pkg::SAMPLE_BITS_D-1:0] out_encoded,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [0:0]                                cfg_index,
  input  logic [ANGLE_BITS-1:0]                     cfg_data
);
  import ambi_pkg::*;

  logic [ANGLE_BITS-1:0] azimuth_r, elevation_r;
  logic cfg_we, trig_ready, fifo_ne, fifo_full, push;
  item_t in_item, q_item;
  trig_set_t trig;

  assign cfg_ready = 1'b1;
  assign cfg_we = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      azimuth_r <= '0;
      elevation_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AZIMUTH: azimuth_r <= cfg_data;
        default: elevation_r <= cfg_data;
      endcase
    end
  end

  ambi_trig #(.TABLE_SIZE(TABLE_SIZE), .ANGLE_BITS(ANGLE_BITS)) u_trig (
    .clk, .rst_n, .azimuth(azimuth_r), .elevation(elevation_r),
    .recalc(cfg_we), .ready(trig_ready), .trig(trig)
  );

  assign busy = fifo_full || !trig_ready;
  assign push = start && !busy;
  assign in_item.sample = in_sample;
  assign in_item.channel = in_channel;

  ambi_fifo u_fifo (
    .clk, .rst_n, .push, .din(in_item), .pop(fifo_ne),
    .not_empty(fifo_ne), .full(fifo_full), .dout(q_item)
  );

  ambi_gain u_gain (
    .clk, .rst_n, .in_vld(fifo_ne), .item(q_item), .trig,
    .out_vld(out_valid), .out_val(out_encoded)
  );
endmodule
